FILE: sv/qpd_pkg.sv
// ----------------------------------------------------------------------------
// qpd_pkg
// Shared types, constants and tables of the quaternion PD joint torque core.
// ----------------------------------------------------------------------------
package qpd_pkg;

   localparam int JOINTS_DEF = 64;

   localparam logic [15:0] PROP_GAIN_RST  = 16'd5000;
   localparam logic [15:0] DERIV_GAIN_RST = 16'd10;
   localparam logic [15:0] STEP_RATE_RST  = 16'd1000;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_PROP_GAIN  = 2'd0;
   localparam logic [1:0] CSR_DERIV_GAIN = 2'd1;
   localparam logic [1:0] CSR_STEP_RATE  = 2'd2;

   localparam logic [19:0] PI_Q16      = 20'd205887;
   localparam logic [19:0] HALF_PI_Q16 = 20'd102944;

   // Hamilton product: term j of row i is a[j] * b[i ^ j]; a set bit at
   // position 4*i+j marks a subtracted term.
   localparam logic [15:0] QMUL_NEG = 16'h428E;

   typedef struct packed {
      logic [5:0]  parent_index;
      logic [63:0] child_quat;
      logic [63:0] parent_quat;
      logic [63:0] key_rot;
   } req_type;

   typedef struct packed {
      logic signed [39:0] torque_x;
      logic signed [39:0] torque_y;
      logic signed [39:0] torque_z;
      logic               apply;
   } rsp_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_CLEAR,
      OP_MUL_T,
      OP_STORE_T,
      OP_MUL_N,
      OP_STORE_N,
      OP_MUL_E,
      OP_DIV_E,
      OP_STORE_E,
      OP_MUL_W,
      OP_SQ_INIT,
      OP_SQ_STEP,
      OP_CO_INIT,
      OP_CO_STEP,
      OP_ERR,
      OP_PD1,
      OP_PD2,
      OP_PD3,
      OP_PD4,
      OP_MUL_TQ,
      OP_DIV_TQ,
      OP_STORE_TQ,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] row;
      logic [3:0] cnt;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
   } dp_status_type;

   // Arctangent of 2^-i in Q.16 radians.
   function automatic logic [19:0] atan_q16(input logic [3:0] i);
      logic [19:0] r;
      unique case (i)
         4'd0:  r = 20'd51472;
         4'd1:  r = 20'd30385;
         4'd2:  r = 20'd16055;
         4'd3:  r = 20'd8150;
         4'd4:  r = 20'd4091;
         4'd5:  r = 20'd2047;
         4'd6:  r = 20'd1024;
         4'd7:  r = 20'd512;
         4'd8:  r = 20'd256;
         4'd9:  r = 20'd128;
         4'd10: r = 20'd64;
         4'd11: r = 20'd32;
         4'd12: r = 20'd16;
         4'd13: r = 20'd8;
         4'd14: r = 20'd4;
         4'd15: r = 20'd2;
         default: r = 20'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: sv/quaternion_pd_joint_torque_core.sv
// ----------------------------------------------------------------------------
// quaternion_pd_joint_torque_core
// PD torque for one joint from child, parent and keyframe quaternions.
// ----------------------------------------------------------------------------
// One word is processed at a time: it is accepted, then the target and the
// norm are formed on the shared multiplier, then each of the four error
// components (four products, then the restoring divider at one quotient bit
// per cycle for a 17-bit quotient), then the clamp and 15 square root steps,
// 16 CORDIC steps, the error and the PD sum, each of the three torque
// components (a 40-bit quotient) and the load of the result register, after
// which rsp_valid rises. A division that saturates finishes at once. A
// finished result waits in the output register while the next word is
// accepted; the block stalls in its last cycle only while the previous result
// is still unclaimed. After reset the block clears every entry of the
// last-error RAM before it takes its first word. Configuration writes take
// effect at once and belong in idle time.
// ----------------------------------------------------------------------------
module quaternion_pd_joint_torque_core #(
   parameter int JOINTS = qpd_pkg::JOINTS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  qpd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output qpd_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_index,
   input  logic [15:0]      csr_wdata
);

   qpd_pkg::dp_cmd_type       cmd;
   qpd_pkg::dp_status_type    status;
   logic [$clog2(JOINTS)-1:0] clr_addr;

   qpd_ctrl #(
      .JOINTS (JOINTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd),
      .clr_addr  (clr_addr)
   );

   qpd_dp #(
      .JOINTS (JOINTS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .clr_addr  (clr_addr),
      .status    (status),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: sv/qpd_ram.sv
// ----------------------------------------------------------------------------
// qpd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module qpd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

FILE: sv/qpd_div.sv
// ----------------------------------------------------------------------------
// qpd_div
// Signed restoring divider, one quotient bit per cycle, truncating toward
// zero; it forms 17-bit or 40-bit quotients and saturates them to 16-bit or
// 40-bit signed results.
// ----------------------------------------------------------------------------
module qpd_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               long_mode,
   input  logic signed [63:0] num,
   input  logic [33:0]        den,
   output logic               busy,
   output logic signed [39:0] quot
);

   localparam int DS_W = 74;

   logic [63:0]     mag;
   logic [DS_W-1:0] lim;
   logic            ovf;
   logic            ge;
   logic [39:0]     pos_max;
   logic [39:0]     neg_max;

   logic [63:0]     rem_ff;
   logic [DS_W-1:0] ds_ff;
   logic [39:0]     q_ff;
   logic [5:0]      cnt_ff;
   logic            busy_ff;
   logic            neg_ff;
   logic            sat_ff;
   logic            long_ff;

   always_comb begin
      mag = num[63] ? 64'(-num) : 64'(num);
      lim = long_mode ? {den, 40'd0} : {23'd0, den, 17'd0};
      ovf = {10'd0, mag} >= lim;
      ge  = {10'd0, rem_ff} >= ds_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= !ovf;
      end else if (busy_ff && cnt_ff == 6'd1) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff  <= mag;
         ds_ff   <= lim >> 1;
         q_ff    <= '0;
         cnt_ff  <= long_mode ? 6'd40 : 6'd17;
         neg_ff  <= num[63];
         sat_ff  <= ovf;
         long_ff <= long_mode;
      end else if (busy_ff) begin
         if (ge) begin
            rem_ff <= rem_ff - ds_ff[63:0];
         end
         q_ff   <= {q_ff[38:0], ge};
         ds_ff  <= ds_ff >> 1;
         cnt_ff <= cnt_ff - 6'd1;
      end
   end

   always_comb begin
      pos_max = long_ff ? 40'h7F_FFFF_FFFF : 40'd32767;
      neg_max = pos_max + 40'd1;
      if (sat_ff) begin
         quot = neg_ff ? -$signed(neg_max) : $signed(pos_max);
      end else if (neg_ff) begin
         quot = (q_ff > neg_max) ? -$signed(neg_max) : -$signed(q_ff);
      end else begin
         quot = (q_ff > pos_max) ? $signed(pos_max) : $signed(q_ff);
      end
   end

   assign busy = busy_ff;

endmodule

FILE: sv/qpd_dp.sv
// ----------------------------------------------------------------------------
// qpd_dp
// Datapath: operand registers, shared multiplier and accumulator, square
// root and CORDIC step logic, divider, last-error RAM and result register.
// ----------------------------------------------------------------------------
module qpd_dp #(
   parameter int JOINTS = qpd_pkg::JOINTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  qpd_pkg::dp_cmd_type       cmd,
   input  logic [$clog2(JOINTS)-1:0] clr_addr,
   output qpd_pkg::dp_status_type    status,
   input  qpd_pkg::req_type          req_data,
   input  logic                      csr_wr_en,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_wdata,
   output qpd_pkg::rsp_type          rsp_data
);

   localparam int IDX_W  = $clog2(JOINTS);
   localparam int PIDX_N = 64;

   logic [15:0] prop_ff;
   logic [15:0] deriv_ff;
   logic [15:0] rate_ff;

   logic signed [15:0] c_ff [4];
   logic signed [15:0] p_ff [4];
   logic signed [15:0] k_ff [4];
   logic signed [19:0] t_ff [4];
   logic signed [15:0] e_ff [4];
   logic signed [39:0] tq_ff [3];
   logic [IDX_W-1:0]   idx_ff;
   logic signed [64:0] prod_ff;
   logic signed [39:0] acc_ff;
   logic               pend_ff;
   logic [33:0]        n2_ff;
   logic signed [15:0] w_ff;
   logic [29:0]        v_ff;
   logic [29:0]        res_ff;
   logic [29:0]        bit_ff;
   logic signed [25:0] x_ff;
   logic signed [25:0] y_ff;
   logic signed [19:0] z_ff;
   logic [15:0]        err_ff;
   logic signed [16:0] de_ff;
   logic signed [49:0] pdsum_ff;
   logic signed [47:0] pd_ff;
   qpd_pkg::rsp_type   rsp_ff;

   logic [IDX_W-1:0]   idx_lut [PIDX_N];
   logic [1:0]         xidx;
   logic [1:0]         c_idx;
   logic [1:0]         tq_idx;
   logic signed [15:0] c_sel;
   logic signed [15:0] p_sel;
   logic signed [15:0] k_sel;
   logic signed [19:0] t_sel;
   logic signed [15:0] e_sel;
   logic               qneg;
   logic signed [47:0] mul_a;
   logic signed [16:0] mul_b;
   logic               mul_neg;
   logic signed [64:0] mul_p;
   logic signed [64:0] prod_in;
   logic signed [39:0] acc_sum;
   logic signed [15:0] w_clamp;
   logic [29:0]        sq_trial;
   logic signed [25:0] xs;
   logic signed [25:0] ys;
   logic signed [19:0] atan_s;
   logic [19:0]        z_clamp;
   logic [20:0]        z_round;
   logic [15:0]        err_calc;
   logic [15:0]        last_err;
   logic signed [50:0] pd_sum;
   logic signed [47:0] pd_sat;
   logic [14:0]        s_val;
   logic               div_start;
   logic               div_long;
   logic signed [63:0] div_num;
   logic [33:0]        div_den;
   logic               div_busy;
   logic signed [39:0] div_quot;
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   logic [15:0]        ram_wr_data;

   // Parent index reduction modulo the joint count, fixed at elaboration.
   for (genvar gi = 0; gi < PIDX_N; gi++) begin : g_idx
      assign idx_lut[gi] = IDX_W'(gi % JOINTS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_ff  <= qpd_pkg::PROP_GAIN_RST;
         deriv_ff <= qpd_pkg::DERIV_GAIN_RST;
         rate_ff  <= qpd_pkg::STEP_RATE_RST;
      end else if (csr_wr_en) begin
         if (csr_index == qpd_pkg::CSR_PROP_GAIN) begin
            prop_ff <= csr_wdata;
         end else if (csr_index == qpd_pkg::CSR_DERIV_GAIN) begin
            deriv_ff <= csr_wdata;
         end else if (csr_index == qpd_pkg::CSR_STEP_RATE) begin
            rate_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      xidx    = cmd.row ^ cmd.cnt[1:0];
      c_idx   = (cmd.op == qpd_pkg::OP_MUL_E) ? xidx : cmd.cnt[1:0];
      tq_idx  = cmd.row + 2'd1;
      c_sel   = c_ff[c_idx];
      p_sel   = p_ff[cmd.cnt[1:0]];
      k_sel   = k_ff[xidx];
      t_sel   = t_ff[cmd.cnt[1:0]];
      e_sel   = e_ff[tq_idx];
      qneg    = qpd_pkg::QMUL_NEG[{cmd.row, cmd.cnt[1:0]}];
      s_val   = res_ff[14:0];
      acc_sum = acc_ff + (pend_ff ? prod_ff[39:0] : 40'sd0);

      if (e_ff[0] > 16'sd16384) begin
         w_clamp = 16'sd16384;
      end else if (e_ff[0] < -16'sd16384) begin
         w_clamp = -16'sd16384;
      end else begin
         w_clamp = e_ff[0];
      end

      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      unique case (cmd.op)
         qpd_pkg::OP_MUL_T: begin
            mul_a   = 48'(p_sel);
            mul_b   = 17'(k_sel);
            mul_neg = qneg;
         end
         qpd_pkg::OP_MUL_N: begin
            mul_a = 48'(c_sel);
            mul_b = 17'(c_sel);
         end
         qpd_pkg::OP_MUL_E: begin
            // The conjugate of the child flips the vector components.
            mul_a   = 48'(t_sel);
            mul_b   = 17'(c_sel);
            mul_neg = qneg ^ (xidx != 2'd0);
         end
         qpd_pkg::OP_MUL_W: begin
            mul_a = 48'(w_clamp);
            mul_b = 17'(w_clamp);
         end
         qpd_pkg::OP_PD1: begin
            mul_a = 48'(de_ff);
            mul_b = $signed({1'b0, deriv_ff});
         end
         qpd_pkg::OP_PD2: begin
            mul_a = 48'($signed(prod_ff[33:0]));
            mul_b = $signed({1'b0, rate_ff});
         end
         qpd_pkg::OP_PD3: begin
            mul_a = $signed({32'd0, err_ff});
            mul_b = $signed({1'b0, prop_ff});
         end
         qpd_pkg::OP_MUL_TQ: begin
            mul_a = pd_ff;
            mul_b = 17'(e_sel);
         end
         default: begin
         end
      endcase
      mul_p   = 65'(mul_a) * 65'(mul_b);
      prod_in = mul_neg ? -mul_p : mul_p;

      sq_trial = res_ff + bit_ff;

      xs     = x_ff >>> cmd.cnt;
      ys     = y_ff >>> cmd.cnt;
      atan_s = $signed(qpd_pkg::atan_q16(cmd.cnt));

      if (z_ff < 20'sd0) begin
         z_clamp = 20'd0;
      end else if ($unsigned(z_ff) > qpd_pkg::PI_Q16) begin
         z_clamp = qpd_pkg::PI_Q16;
      end else begin
         z_clamp = $unsigned(z_ff);
      end
      z_round  = {1'b0, z_clamp} + 21'd2;
      err_calc = z_round[17:2];

      pd_sum = 51'(pdsum_ff) + prod_ff[50:0];
      if (pd_sum > 51'sh7FFF_FFFF_FFFF) begin
         pd_sat = 48'sh7FFF_FFFF_FFFF;
      end else if (pd_sum < -51'sh8000_0000_0000) begin
         pd_sat = -48'sh8000_0000_0000;
      end else begin
         pd_sat = pd_sum[47:0];
      end

      div_start = (cmd.op == qpd_pkg::OP_DIV_E) || (cmd.op == qpd_pkg::OP_DIV_TQ);
      div_long  = (cmd.op == qpd_pkg::OP_DIV_TQ);
      div_num   = div_long ? prod_ff[63:0] : $signed({{10{acc_sum[39]}}, acc_sum, 14'd0});
      div_den   = div_long ? {14'd0, s_val, 5'd0} : n2_ff;

      ram_wr_en   = (cmd.op == qpd_pkg::OP_CLEAR) || (cmd.op == qpd_pkg::OP_ERR);
      ram_wr_addr = (cmd.op == qpd_pkg::OP_CLEAR) ? clr_addr : idx_ff;
      ram_wr_data = (cmd.op == qpd_pkg::OP_CLEAR) ? 16'd0 : err_calc;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (cmd.op == qpd_pkg::OP_MUL_T || cmd.op == qpd_pkg::OP_MUL_N ||
                   cmd.op == qpd_pkg::OP_MUL_E) begin
         pend_ff <= 1'b1;
      end else if (cmd.op == qpd_pkg::OP_STORE_T || cmd.op == qpd_pkg::OP_STORE_N ||
                   cmd.op == qpd_pkg::OP_DIV_E) begin
         pend_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      unique case (cmd.op)
         qpd_pkg::OP_LOAD: begin
            for (int i = 0; i < 4; i++) begin
               c_ff[i] <= $signed(req_data.child_quat[63-16*i -: 16]);
               p_ff[i] <= $signed(req_data.parent_quat[63-16*i -: 16]);
               k_ff[i] <= $signed(req_data.key_rot[63-16*i -: 16]);
            end
            idx_ff <= idx_lut[req_data.parent_index];
         end
         qpd_pkg::OP_MUL_T, qpd_pkg::OP_MUL_N, qpd_pkg::OP_MUL_E: begin
            acc_ff <= (cmd.cnt[1:0] == 2'd0) ? 40'sd0 : acc_sum;
         end
         qpd_pkg::OP_STORE_T: begin
            // Round half up and drop fourteen fraction bits.
            t_ff[cmd.row] <= 20'($signed(acc_sum + 40'sd8192) >>> 14);
         end
         qpd_pkg::OP_STORE_N: begin
            n2_ff <= acc_sum[33:0];
         end
         qpd_pkg::OP_STORE_E: begin
            e_ff[cmd.row] <= (n2_ff == 34'd0) ? 16'sd0 : div_quot[15:0];
         end
         qpd_pkg::OP_MUL_W: begin
            w_ff <= w_clamp;
         end
         qpd_pkg::OP_SQ_INIT: begin
            v_ff   <= 30'h1000_0000 - prod_ff[29:0];
            res_ff <= 30'd0;
            bit_ff <= 30'h1000_0000;
         end
         qpd_pkg::OP_SQ_STEP: begin
            if (v_ff >= sq_trial) begin
               v_ff   <= v_ff - sq_trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         qpd_pkg::OP_CO_INIT: begin
            // Start in the right half plane; a negative w starts a quarter
            // turn ahead.
            if (w_ff < 16'sd0) begin
               x_ff <= $signed({11'd0, s_val}) <<< 8;
               y_ff <= 26'(-w_ff) <<< 8;
               z_ff <= $signed(qpd_pkg::HALF_PI_Q16);
            end else begin
               x_ff <= 26'(w_ff) <<< 8;
               y_ff <= $signed({11'd0, s_val}) <<< 8;
               z_ff <= 20'sd0;
            end
         end
         qpd_pkg::OP_CO_STEP: begin
            if (y_ff >= 26'sd0) begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + atan_s;
            end else begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - atan_s;
            end
         end
         qpd_pkg::OP_ERR: begin
            err_ff <= err_calc;
            de_ff  <= $signed({1'b0, err_calc}) - $signed({1'b0, last_err});
         end
         qpd_pkg::OP_PD3: begin
            pdsum_ff <= prod_ff[49:0];
         end
         qpd_pkg::OP_PD4: begin
            pd_ff <= pd_sat;
         end
         qpd_pkg::OP_STORE_TQ: begin
            tq_ff[cmd.row] <= (s_val == 15'd0) ? 40'sd0 : div_quot;
         end
         qpd_pkg::OP_OUT: begin
            rsp_ff.torque_x <= tq_ff[0];
            rsp_ff.torque_y <= tq_ff[1];
            rsp_ff.torque_z <= tq_ff[2];
            rsp_ff.apply    <= (s_val != 15'd0) &&
                               (tq_ff[0] != 40'sd0 || tq_ff[1] != 40'sd0 ||
                                tq_ff[2] != 40'sd0);
         end
         default: begin
         end
      endcase
   end

   qpd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .long_mode (div_long),
      .num       (div_num),
      .den       (div_den),
      .busy      (div_busy),
      .quot      (div_quot)
   );

   qpd_ram #(
      .WIDTH (16),
      .DEPTH (JOINTS)
   ) u_last_err (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.op == qpd_pkg::OP_LOAD),
      .rd_addr (idx_lut[req_data.parent_index]),
      .rd_data (last_err)
   );

   assign status.div_busy = div_busy;
   assign rsp_data        = rsp_ff;

endmodule

FILE: sv/qpd_ctrl.sv
// ----------------------------------------------------------------------------
// qpd_ctrl
// Controller: sequences the datapath through one word, clears the last-error
// RAM after reset and runs both handshakes.
// ----------------------------------------------------------------------------
module qpd_ctrl #(
   parameter int JOINTS = qpd_pkg::JOINTS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  qpd_pkg::dp_status_type    status,
   output qpd_pkg::dp_cmd_type       cmd,
   output logic [$clog2(JOINTS)-1:0] clr_addr
);

   localparam int IDX_W = $clog2(JOINTS);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_T_MUL, S_T_STORE, S_N_MUL, S_N_STORE,
      S_E_MUL, S_E_DIV, S_E_WAIT, S_E_STORE,
      S_W_MUL, S_SQ_INIT, S_SQ_STEP, S_CO_INIT, S_CO_STEP, S_ERR,
      S_PD1, S_PD2, S_PD3, S_PD4,
      S_TQ_MUL, S_TQ_DIV, S_TQ_WAIT, S_TQ_STORE, S_OUT
   } state_type;

   state_type        state_ff, state_in;
   logic [1:0]       row_ff, row_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_fire;

   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      cnt_in   = cnt_ff;
      clr_in   = clr_ff;
      cmd.op   = qpd_pkg::OP_NONE;
      cmd.row  = row_ff;
      cmd.cnt  = cnt_ff;
      out_fire = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.op = qpd_pkg::OP_CLEAR;
            clr_in = clr_ff + IDX_W'(1);
            if (clr_ff == IDX_W'(JOINTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op   = qpd_pkg::OP_LOAD;
               state_in = S_T_MUL;
               row_in   = 2'd0;
               cnt_in   = 4'd0;
            end
         end
         S_T_MUL: begin
            cmd.op = qpd_pkg::OP_MUL_T;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               state_in = S_T_STORE;
            end
         end
         S_T_STORE: begin
            cmd.op = qpd_pkg::OP_STORE_T;
            cnt_in = 4'd0;
            row_in = row_ff + 2'd1;
            state_in = (row_ff == 2'd3) ? S_N_MUL : S_T_MUL;
         end
         S_N_MUL: begin
            cmd.op = qpd_pkg::OP_MUL_N;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               state_in = S_N_STORE;
            end
         end
         S_N_STORE: begin
            cmd.op   = qpd_pkg::OP_STORE_N;
            cnt_in   = 4'd0;
            state_in = S_E_MUL;
         end
         S_E_MUL: begin
            cmd.op = qpd_pkg::OP_MUL_E;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd3) begin
               state_in = S_E_DIV;
            end
         end
         S_E_DIV: begin
            cmd.op   = qpd_pkg::OP_DIV_E;
            state_in = S_E_WAIT;
         end
         S_E_WAIT: begin
            if (!status.div_busy) begin
               state_in = S_E_STORE;
            end
         end
         S_E_STORE: begin
            cmd.op = qpd_pkg::OP_STORE_E;
            cnt_in = 4'd0;
            row_in = row_ff + 2'd1;
            state_in = (row_ff == 2'd3) ? S_W_MUL : S_E_MUL;
         end
         S_W_MUL: begin
            cmd.op   = qpd_pkg::OP_MUL_W;
            state_in = S_SQ_INIT;
         end
         S_SQ_INIT: begin
            cmd.op   = qpd_pkg::OP_SQ_INIT;
            cnt_in   = 4'd0;
            state_in = S_SQ_STEP;
         end
         S_SQ_STEP: begin
            cmd.op = qpd_pkg::OP_SQ_STEP;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd14) begin
               state_in = S_CO_INIT;
            end
         end
         S_CO_INIT: begin
            cmd.op   = qpd_pkg::OP_CO_INIT;
            cnt_in   = 4'd0;
            state_in = S_CO_STEP;
         end
         S_CO_STEP: begin
            cmd.op = qpd_pkg::OP_CO_STEP;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd15) begin
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            cmd.op   = qpd_pkg::OP_ERR;
            state_in = S_PD1;
         end
         S_PD1: begin
            cmd.op   = qpd_pkg::OP_PD1;
            state_in = S_PD2;
         end
         S_PD2: begin
            cmd.op   = qpd_pkg::OP_PD2;
            state_in = S_PD3;
         end
         S_PD3: begin
            cmd.op   = qpd_pkg::OP_PD3;
            state_in = S_PD4;
         end
         S_PD4: begin
            cmd.op   = qpd_pkg::OP_PD4;
            row_in   = 2'd0;
            state_in = S_TQ_MUL;
         end
         S_TQ_MUL: begin
            cmd.op   = qpd_pkg::OP_MUL_TQ;
            state_in = S_TQ_DIV;
         end
         S_TQ_DIV: begin
            cmd.op   = qpd_pkg::OP_DIV_TQ;
            state_in = S_TQ_WAIT;
         end
         S_TQ_WAIT: begin
            if (!status.div_busy) begin
               state_in = S_TQ_STORE;
            end
         end
         S_TQ_STORE: begin
            cmd.op = qpd_pkg::OP_STORE_TQ;
            row_in = row_ff + 2'd1;
            state_in = (row_ff == 2'd2) ? S_OUT : S_TQ_MUL;
         end
         S_OUT: begin
            // Wait here only while the previous word is still unclaimed.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op   = qpd_pkg::OP_OUT;
               out_fire = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (out_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         row_ff       <= 2'd0;
         cnt_ff       <= 4'd0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign clr_addr  = clr_ff;

endmodule
